// ===== src/cfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfdc_pkg: shared types and constants
// Item and result structs, table entry layout, register indexes, path codes
// and the request struct of the serial arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cfdc_pkg;

	localparam int TABLE_POINTS_DEF = 16;
	localparam logic [11:0] CODE_MAX = 12'hFFF;

	// command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// result path codes
	localparam logic [1:0] PATH_IDEAL  = 2'd0;
	localparam logic [1:0] PATH_BELOW  = 2'd1;
	localparam logic [1:0] PATH_INTERP = 2'd2;
	localparam logic [1:0] PATH_ABOVE  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_TABLE_VALID   = 3'd0;
	localparam logic [2:0] REG_POINTS_IN_USE = 3'd1;
	localparam logic [2:0] REG_IDEAL_SCALE   = 3'd2;
	localparam logic [2:0] REG_CODE_FLOOR    = 3'd3;
	localparam logic [2:0] REG_CODE_CEILING  = 3'd4;

	// arithmetic unit operations
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  point_index;
		logic [11:0] point_code;
		logic [27:0] point_freq;
		logic [17:0] point_correction;
		logic [27:0] target_freq;
	} in_item_t;

	typedef struct packed {
		logic [11:0] code_word;
		logic [1:0]  path_taken;
		logic        load_ack;
	} out_item_t;

	typedef struct packed {
		logic [11:0] code;
		logic [27:0] freq;
		logic [17:0] corr;
	} entry_t;

	typedef struct packed {
		logic       go;
		logic       op;
		logic [6:0] steps;
	} alu_req_t;

endpackage
`default_nettype wire

// ===== src/cfdc_ram.sv =====
// ----------------------------------------------------------------------------
// cfdc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module cfdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/cfdc_alu.sv =====
// ----------------------------------------------------------------------------
// cfdc_alu: bit-serial multiplier and restoring divider
// Multiply retires one multiplier bit a cycle (shift and add); divide
// retires one quotient bit a cycle (shift, compare, subtract).
// ----------------------------------------------------------------------------
`default_nettype none
module cfdc_alu (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfdc_pkg::alu_req_t req,
	input  wire logic [63:0]        opa,
	input  wire logic [63:0]        opb,
	output logic                    done,
	output logic [63:0]             res
);
	import cfdc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic        op_q;
	logic [63:0] acc_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] trial;
	logic        ge;

	// trial subtraction for one quotient bit
	assign trial = {acc_q[62:0], a_q[63]};
	assign ge    = trial >= b_q;

	// step counter and completion strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand shift registers
	always_ff @(posedge clk) begin
		if (req.go) begin
			op_q  <= req.op;
			acc_q <= '0;
			a_q   <= opa;
			b_q   <= opb;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= {a_q[62:0], 1'b0};
				b_q <= {1'b0, b_q[63:1]};
			end else begin
				acc_q <= ge ? trial - b_q : trial;
				a_q   <= {a_q[62:0], ge};
			end
		end
	end

	assign done = done_q;
	assign res  = (op_q == OP_MUL) ? acc_q : a_q;
endmodule
`default_nettype wire

// ===== src/calibrated_freq_to_dac_code.sv =====
// ----------------------------------------------------------------------------
// calibrated_freq_to_dac_code: calibrated frequency to DAC code converter
// Loads calibration points into a table and turns target frequencies into
// corrected DAC codes by ideal scaling, end-point scaling or interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on "item" with start high; it is taken at an edge where
//   busy is low. A load (cmd 0) writes one table slot and returns its beat
//   on the next cycle. A lookup walks the table one entry read at a time
//   (first entry, last entry, then pairs), then runs its arithmetic on one
//   bit-serial unit at one bit per cycle: target x scale for the ideal
//   formula; code x correction, x target, then a divide for end points;
//   a divide, a multiply, target x scale and x correction to interpolate.
//   Each result beat is shown on "result" for one cycle with done high;
//   the receiver cannot stall it. A lookup holds busy high until its beat.
//   Configuration writes on cfg_valid are always taken (cfg_ready is high)
//   and belong to idle periods. Reset clears the registers to their
//   defaults; table slots hold nothing until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module calibrated_freq_to_dac_code #(
	parameter int TABLE_POINTS = cfdc_pkg::TABLE_POINTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire cfdc_pkg::in_item_t   item,
	output logic                      done,
	output cfdc_pkg::out_item_t       result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data
);
	import cfdc_pkg::*;

	localparam int AW = $clog2(TABLE_POINTS);
	localparam logic [6:0] TP7 = 7'(TABLE_POINTS);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RD0W   = 4'd1;
	localparam logic [3:0] ST_CHK0   = 4'd2;
	localparam logic [3:0] ST_RDLW   = 4'd3;
	localparam logic [3:0] ST_CHKL   = 4'd4;
	localparam logic [3:0] ST_RDWW   = 4'd5;
	localparam logic [3:0] ST_CHKW   = 4'd6;
	localparam logic [3:0] ST_SC_M1  = 4'd7;
	localparam logic [3:0] ST_SC_M2  = 4'd8;
	localparam logic [3:0] ST_SC_DIV = 4'd9;
	localparam logic [3:0] ST_IP_DIV = 4'd10;
	localparam logic [3:0] ST_IP_M1  = 4'd11;
	localparam logic [3:0] ST_IP_M2  = 4'd12;
	localparam logic [3:0] ST_IP_M3  = 4'd13;
	localparam logic [3:0] ST_ID_MUL = 4'd14;

	// configuration registers
	logic        valid_q;
	logic [4:0]  npts_q;
	logic [31:0] scale_q;
	logic [11:0] floor_q;
	logic [11:0] ceil_q;

	// control and datapath registers
	logic [3:0]  state_q;
	logic [AW:0] j_q;
	logic [AW:0] n_q;
	logic [27:0] t_q;
	logic [1:0]  path_q;
	entry_t      p_q;
	entry_t      s_q;
	logic [17:0] corr_q;
	logic        done_q;
	out_item_t   res_q;
	logic        go_q;
	logic        aop_q;
	logic [6:0]  steps_q;
	logic [63:0] opa_q;
	logic [63:0] opb_q;

	// combinational helpers
	logic        accept;
	logic        we;
	logic [6:0]  idx7;
	logic [6:0]  np7;
	logic [6:0]  n7;
	logic [AW:0] n_new;
	logic [$bits(entry_t)-1:0] rdata_raw;
	entry_t      rd;
	alu_req_t    alu_req;
	logic        alu_done;
	logic [63:0] alu_res;
	logic [63:0] rnd;
	logic [31:0] rnd_hi;
	logic [11:0] sat_code;
	logic [31:0] lo_clamp;
	logic [11:0] ip_code;
	logic [11:0] below_code;
	logic [11:0] above_code;
	logic [63:0] below_lo;
	logic [35:0] corr_wide;
	logic [35:0] corr_rnd;
	logic [17:0] cdiff;

	assign accept    = start && !busy;
	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	// table slot write on a load beat
	assign idx7 = {3'b000, item.point_index};
	assign we   = accept && (item.cmd == CMD_LOAD) && (idx7 < TP7);

	// points in use, saturated to the table size
	assign np7   = {2'b00, npts_q};
	assign n7    = (np7 > TP7) ? TP7 : np7;
	assign n_new = n7[AW:0];

	cfdc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_POINTS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (idx7[AW-1:0]),
		.wdata ({item.point_code, item.point_freq, item.point_correction}),
		.raddr (j_q[AW-1:0]),
		.rdata (rdata_raw)
	);
	assign rd = entry_t'(rdata_raw);

	assign alu_req = '{go: go_q, op: aop_q, steps: steps_q};

	cfdc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (opa_q),
		.opb    (opb_q),
		.done   (alu_done),
		.res    (alu_res)
	);

	// round the top word half up and saturate for the ideal formula
	assign rnd      = alu_res + 64'h0000_0000_8000_0000;
	assign rnd_hi   = rnd[63:32];
	assign sat_code = (rnd_hi > 32'(CODE_MAX)) ? CODE_MAX : rnd_hi[11:0];

	// interpolated code: floor first, then ceiling
	assign lo_clamp = (rnd_hi < 32'(floor_q)) ? 32'(floor_q) : rnd_hi;
	assign ip_code  = (lo_clamp > 32'(ceil_q)) ? ceil_q : lo_clamp[11:0];

	// end-point codes from the quotient
	assign below_lo   = (alu_res < 64'(floor_q)) ? 64'(floor_q) : alu_res;
	assign below_code = (below_lo > 64'(CODE_MAX)) ? CODE_MAX : below_lo[11:0];
	assign above_code = (alu_res > 64'(ceil_q)) ? ceil_q : alu_res[11:0];

	// interpolated correction, rounded to Q2.16
	assign cdiff     = (s_q.corr >= p_q.corr) ? s_q.corr - p_q.corr : p_q.corr - s_q.corr;
	assign corr_wide = (s_q.corr >= p_q.corr)
		? {2'b00, p_q.corr, 16'h0000} + alu_res[35:0]
		: {2'b00, p_q.corr, 16'h0000} - alu_res[35:0];
	assign corr_rnd  = corr_wide + 36'h0_0000_8000;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			npts_q  <= '0;
			scale_q <= '0;
			floor_q <= 12'd1;
			ceil_q  <= CODE_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TABLE_VALID:   valid_q <= cfg_data[0];
				REG_POINTS_IN_USE: npts_q  <= cfg_data[4:0];
				REG_IDEAL_SCALE:   scale_q <= cfg_data;
				REG_CODE_FLOOR:    floor_q <= cfg_data[11:0];
				REG_CODE_CEILING:  ceil_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// sequencer: table walk and arithmetic launches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			n_q     <= '0;
			t_q     <= '0;
			path_q  <= PATH_IDEAL;
			p_q     <= '0;
			s_q     <= '0;
			corr_q  <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
			go_q    <= 1'b0;
			aop_q   <= OP_MUL;
			steps_q <= '0;
			opa_q   <= '0;
			opb_q   <= '0;
		end else begin
			done_q <= 1'b0;
			go_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_LOAD) begin
							res_q  <= '{code_word: 12'd0, path_taken: PATH_IDEAL, load_ack: 1'b1};
							done_q <= 1'b1;
						end else begin
							t_q <= item.target_freq;
							n_q <= n_new;
							j_q <= '0;
							if (!valid_q || (n7 < 7'd2)) begin
								path_q  <= PATH_IDEAL;
								go_q    <= 1'b1;
								aop_q   <= OP_MUL;
								opa_q   <= 64'(item.target_freq);
								opb_q   <= 64'(scale_q);
								steps_q <= 7'd32;
								state_q <= ST_ID_MUL;
							end else begin
								state_q <= ST_RD0W;
							end
						end
					end
				end
				ST_RD0W: state_q <= ST_CHK0;
				ST_CHK0: begin
					p_q <= rd;
					s_q <= rd;
					if (t_q <= rd.freq) begin
						path_q <= PATH_BELOW;
						if (rd.freq == 28'd0) begin
							res_q   <= '{code_word: floor_q, path_taken: PATH_BELOW, load_ack: 1'b0};
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							go_q    <= 1'b1;
							aop_q   <= OP_MUL;
							opa_q   <= 64'(rd.code);
							opb_q   <= 64'(rd.corr);
							steps_q <= 7'd18;
							state_q <= ST_SC_M1;
						end
					end else begin
						j_q     <= n_q - 1'b1;
						state_q <= ST_RDLW;
					end
				end
				ST_RDLW: state_q <= ST_CHKL;
				ST_CHKL: begin
					s_q <= rd;
					if (t_q >= rd.freq) begin
						path_q <= PATH_ABOVE;
						if (rd.freq == 28'd0) begin
							res_q   <= '{code_word: 12'd0, path_taken: PATH_ABOVE, load_ack: 1'b0};
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							go_q    <= 1'b1;
							aop_q   <= OP_MUL;
							opa_q   <= 64'(rd.code);
							opb_q   <= 64'(rd.corr);
							steps_q <= 7'd18;
							state_q <= ST_SC_M1;
						end
					end else begin
						j_q     <= {{AW{1'b0}}, 1'b1};
						state_q <= ST_RDWW;
					end
				end
				ST_RDWW: state_q <= ST_CHKW;
				ST_CHKW: begin
					if ((t_q >= p_q.freq) && (t_q <= rd.freq)) begin
						// bracketing pair found: fraction first
						s_q     <= rd;
						path_q  <= PATH_INTERP;
						go_q    <= 1'b1;
						if (rd.freq == p_q.freq) begin
							aop_q   <= OP_MUL;
							opa_q   <= '0;
							opb_q   <= '0;
							steps_q <= 7'd18;
							state_q <= ST_IP_M1;
						end else begin
							aop_q   <= OP_DIV;
							opa_q   <= {20'd0, t_q - p_q.freq, 16'd0};
							opb_q   <= {36'd0, rd.freq - p_q.freq};
							steps_q <= 7'd64;
							state_q <= ST_IP_DIV;
						end
					end else begin
						p_q <= rd;
						if (j_q == n_q - 1'b1) begin
							// no pair brackets the target
							path_q  <= PATH_IDEAL;
							go_q    <= 1'b1;
							aop_q   <= OP_MUL;
							opa_q   <= 64'(t_q);
							opb_q   <= 64'(scale_q);
							steps_q <= 7'd32;
							state_q <= ST_ID_MUL;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_RDWW;
						end
					end
				end
				ST_SC_M1: begin
					if (alu_done) begin
						go_q    <= 1'b1;
						aop_q   <= OP_MUL;
						opa_q   <= alu_res;
						opb_q   <= 64'(t_q);
						steps_q <= 7'd28;
						state_q <= ST_SC_M2;
					end
				end
				ST_SC_M2: begin
					if (alu_done) begin
						go_q    <= 1'b1;
						aop_q   <= OP_DIV;
						opa_q   <= alu_res + {21'd0, s_q.freq, 15'd0};
						opb_q   <= {20'd0, s_q.freq, 16'd0};
						steps_q <= 7'd64;
						state_q <= ST_SC_DIV;
					end
				end
				ST_SC_DIV: begin
					if (alu_done) begin
						res_q <= '{
							code_word: (path_q == PATH_BELOW) ? below_code : above_code,
							path_taken: path_q, load_ack: 1'b0};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_IP_DIV: begin
					if (alu_done) begin
						go_q    <= 1'b1;
						aop_q   <= OP_MUL;
						opa_q   <= alu_res;
						opb_q   <= 64'(cdiff);
						steps_q <= 7'd18;
						state_q <= ST_IP_M1;
					end
				end
				ST_IP_M1: begin
					if (alu_done) begin
						corr_q  <= corr_rnd[33:16];
						go_q    <= 1'b1;
						aop_q   <= OP_MUL;
						opa_q   <= 64'(t_q);
						opb_q   <= 64'(scale_q);
						steps_q <= 7'd32;
						state_q <= ST_IP_M2;
					end
				end
				ST_IP_M2: begin
					if (alu_done) begin
						go_q    <= 1'b1;
						aop_q   <= OP_MUL;
						opa_q   <= {16'd0, alu_res[63:16]};
						opb_q   <= 64'(corr_q);
						steps_q <= 7'd18;
						state_q <= ST_IP_M3;
					end
				end
				ST_IP_M3: begin
					if (alu_done) begin
						res_q   <= '{code_word: ip_code, path_taken: PATH_INTERP, load_ack: 1'b0};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ID_MUL: begin
					if (alu_done) begin
						res_q   <= '{code_word: sat_code, path_taken: PATH_IDEAL, load_ack: 1'b0};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
